FILE: rtl/jtse_pkg.sv
package jtse_pkg;

  localparam int unsigned MAX_TITLES  = 15;
  localparam int unsigned TITLE_BYTES = 128;

  // Counter widths follow from the limits above.
  localparam int unsigned TIDX_W = $clog2(MAX_TITLES + 1);
  localparam int unsigned CCNT_W = $clog2(TITLE_BYTES);

  // Result queue between the parser and the output port.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Byte values the parser looks for.
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_LOW_N  = 8'd110;
  localparam logic [7:0] CH_LOW_R  = 8'd114;
  localparam logic [7:0] CH_LOW_T  = 8'd116;
  localparam logic [7:0] CH_LOW_U  = 8'd117;
  localparam logic [7:0] CH_DEL    = 8'd127;

  localparam logic [2:0] KEY_LAST_POS = 3'd7;
  localparam logic [2:0] USKIP_LEN    = 3'd4;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_DONE = 2'd1,
    KIND_DROP = 2'd2,
    KIND_END  = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    MODE_SEARCH = 6'b000001,
    MODE_GAP    = 6'b000010,
    MODE_STR    = 6'b000100,
    MODE_ESC    = 6'b001000,
    MODE_USKIP  = 6'b010000,
    MODE_FULL   = 6'b100000
  } mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] slot;
    logic [6:0] out_char;
    logic [3:0] title_total;
  } result_t;

  // Up to two result words per input byte; res[0] goes out first.
  typedef struct packed {
    logic [1:0]        n;
    result_t [1:0]     res;
  } step_t;

  // The key pattern "title": one byte per match position.
  function automatic logic [7:0] key_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = CH_QUOTE;
      3'd1:    ch = 8'd116;
      3'd2:    ch = 8'd105;
      3'd3:    ch = 8'd116;
      3'd4:    ch = 8'd108;
      3'd5:    ch = 8'd101;
      3'd6:    ch = CH_QUOTE;
      default: ch = 8'd58;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/jtse_parse.sv
module jtse_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          in_byte_i,
  input  logic                is_last_i,
  input  logic                no_byte_i,
  output jtse_pkg::step_t     step_o
);

  jtse_pkg::mode_e                   mode_q, mode_d;
  logic [2:0]                        match_q, match_d;
  logic [2:0]                        skip_q, skip_d;
  logic [jtse_pkg::CCNT_W-1:0]       ccnt_q, ccnt_d;
  logic [jtse_pkg::TIDX_W-1:0]       tidx_q, tidx_d;

  logic [7:0]                        c;
  logic [7:0]                        v;
  logic                              keep;
  logic                              have_char;
  logic                              have_done;
  logic [jtse_pkg::TIDX_W-1:0]       done_slot;
  logic                              in_string;
  jtse_pkg::result_t                 end_res;

  always_comb begin
    mode_d    = mode_q;
    match_d   = match_q;
    skip_d    = skip_q;
    ccnt_d    = ccnt_q;
    tidx_d    = tidx_q;
    keep      = 1'b0;
    v         = '0;
    have_char = 1'b0;
    have_done = 1'b0;
    done_slot = tidx_q;
    step_o    = '0;
    c         = (in_byte_i == jtse_pkg::CH_NUL) ? jtse_pkg::CH_SPACE : in_byte_i;

    if (!no_byte_i) begin
      case (mode_q)
        jtse_pkg::MODE_SEARCH: begin
          if (c == jtse_pkg::key_char(match_q)) begin
            if (match_q == jtse_pkg::KEY_LAST_POS) begin
              match_d = '0;
              mode_d  = jtse_pkg::MODE_GAP;
            end else begin
              match_d = match_q + 3'd1;
            end
          end else if (match_q == jtse_pkg::KEY_LAST_POS && c == jtse_pkg::CH_LOW_T) begin
            // A t where the colon belongs restarts the key at "t, reusing the quote before it.
            match_d = 3'd2;
          end else if (c == jtse_pkg::CH_QUOTE) begin
            match_d = 3'd1;
          end else begin
            match_d = '0;
          end
        end
        jtse_pkg::MODE_GAP: begin
          if (c inside {jtse_pkg::CH_SPACE, jtse_pkg::CH_TAB, jtse_pkg::CH_LF,
                        jtse_pkg::CH_CR}) begin
            mode_d = jtse_pkg::MODE_GAP;
          end else if (c == jtse_pkg::CH_QUOTE) begin
            ccnt_d = '0;
            mode_d = jtse_pkg::MODE_STR;
          end else begin
            match_d = '0;
            mode_d  = jtse_pkg::MODE_SEARCH;
          end
        end
        jtse_pkg::MODE_STR: begin
          if (c == jtse_pkg::CH_BSLASH) begin
            mode_d = jtse_pkg::MODE_ESC;
          end else if (c == jtse_pkg::CH_QUOTE) begin
            if (ccnt_q != '0) begin
              have_done = 1'b1;
              tidx_d    = tidx_q + jtse_pkg::TIDX_W'(1);
            end
            ccnt_d  = '0;
            match_d = '0;
            mode_d  = (tidx_d >= jtse_pkg::TIDX_W'(jtse_pkg::MAX_TITLES)) ?
                      jtse_pkg::MODE_FULL : jtse_pkg::MODE_SEARCH;
          end else begin
            keep = 1'b1;
            v    = c;
          end
        end
        jtse_pkg::MODE_ESC: begin
          keep   = 1'b1;
          mode_d = jtse_pkg::MODE_STR;
          if (c inside {jtse_pkg::CH_LOW_N, jtse_pkg::CH_LOW_T, jtse_pkg::CH_LOW_R}) begin
            v = jtse_pkg::CH_SPACE;
          end else if (c == jtse_pkg::CH_LOW_U) begin
            v      = jtse_pkg::CH_QMARK;
            skip_d = jtse_pkg::USKIP_LEN;
            mode_d = jtse_pkg::MODE_USKIP;
          end else begin
            v = c;
          end
        end
        jtse_pkg::MODE_USKIP: begin
          if (skip_q != '0) begin
            skip_d = skip_q - 3'd1;
          end
          if (skip_d == '0) begin
            mode_d = jtse_pkg::MODE_STR;
          end
        end
        jtse_pkg::MODE_FULL: begin
          mode_d = jtse_pkg::MODE_FULL;
        end
        default: begin
          mode_d  = jtse_pkg::MODE_SEARCH;
          match_d = '0;
        end
      endcase

      if (keep && v >= jtse_pkg::CH_SPACE && v < jtse_pkg::CH_DEL &&
          ccnt_q < jtse_pkg::CCNT_W'(jtse_pkg::TITLE_BYTES - 1)) begin
        ccnt_d    = ccnt_q + jtse_pkg::CCNT_W'(1);
        have_char = 1'b1;
      end
    end

    in_string = (mode_d == jtse_pkg::MODE_STR) || (mode_d == jtse_pkg::MODE_ESC) ||
                (mode_d == jtse_pkg::MODE_USKIP);

    end_res             = '0;
    end_res.kind        = jtse_pkg::KIND_END;
    end_res.title_total = 4'(tidx_d);

    if (is_last_i) begin
      if (in_string || have_done) begin
        step_o.n          = 2'd2;
        step_o.res[0].kind = in_string ? jtse_pkg::KIND_DROP : jtse_pkg::KIND_DONE;
        step_o.res[0].slot = in_string ? 4'(tidx_d) : 4'(done_slot);
        step_o.res[1]     = end_res;
      end else begin
        step_o.n      = 2'd1;
        step_o.res[0] = end_res;
      end
      // The end of the stream puts the parser back to its starting point.
      mode_d  = jtse_pkg::MODE_SEARCH;
      match_d = '0;
      skip_d  = '0;
      ccnt_d  = '0;
      tidx_d  = '0;
    end else if (have_char) begin
      step_o.n                = 2'd1;
      step_o.res[0].kind      = jtse_pkg::KIND_CHAR;
      step_o.res[0].slot      = 4'(tidx_q);
      step_o.res[0].out_char  = v[6:0];
    end else if (have_done) begin
      step_o.n           = 2'd1;
      step_o.res[0].kind = jtse_pkg::KIND_DONE;
      step_o.res[0].slot = 4'(done_slot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jtse_pkg::MODE_SEARCH;
      match_q <= '0;
      skip_q  <= '0;
      ccnt_q  <= '0;
      tidx_q  <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      match_q <= match_d;
      skip_q  <= skip_d;
      ccnt_q  <= ccnt_d;
      tidx_q  <= tidx_d;
    end
  end

endmodule

FILE: rtl/json_title_string_extractor.sv
// Extracts the string values of "title": keys from a byte stream, one byte
// per input word. Each kept title character leaves as one output word tagged
// with its slot; a closing quote of a non-empty title gives a completion
// word, and the word with tlast set gives a stream-done word with the title
// count (preceded by a dropped word if it cut a title off, or by a completion
// word if it closed one). The block takes a byte every cycle while the queue
// has room: the input register feeds the parser, whose words go into a
// four-entry result queue that drives the output. Only the end-of-stream byte
// can make two words, and the input stalls only when the queue cannot take two
// more words.
module json_title_string_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // [0] no_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] slot, [10:4] out_char, [14:11] title_total
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  logic                              in_valid_q;
  logic [7:0]                        in_byte_q;
  logic                              in_last_q;
  logic                              in_nob_q;
  logic                              fire;

  jtse_pkg::step_t                   step;
  jtse_pkg::result_t                 queue_q [jtse_pkg::QDEPTH];
  logic [jtse_pkg::QPTR_W-1:0]       wr_ptr_q;
  logic [jtse_pkg::QPTR_W-1:0]       rd_ptr_q;
  logic [jtse_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic [1:0]                        push_n;
  logic                              pop;
  jtse_pkg::result_t                 head;

  // Parse the held byte only when the queue has room for two words.
  assign fire          = in_valid_q && (cnt_q <= jtse_pkg::QCNT_W'(jtse_pkg::QDEPTH - 2));
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
      in_nob_q  <= s_axis_tuser;
    end
  end

  jtse_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_byte_i (in_byte_q),
    .is_last_i (in_last_q),
    .no_byte_i (in_nob_q),
    .step_o    (step)
  );

  assign push_n = fire ? step.n : 2'd0;
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign cnt_d  = cnt_q + jtse_pkg::QCNT_W'(push_n) - jtse_pkg::QCNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + jtse_pkg::QPTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + jtse_pkg::QPTR_W'(pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= step.res[0];
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + jtse_pkg::QPTR_W'(1)] <= step.res[1];
    end
  end

  assign head          = queue_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tdata  = {1'b0, head.title_total, head.out_char, head.slot};

endmodule
